@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ src/erf_pkg.sv @@
// Shared types, constants and helpers of the Elman RNN step engine.
`timescale 1ns / 1ps
package erf_pkg;

    localparam int LAYERS_DEF    = 4;
    localparam int HIDDEN_DEF    = 32;
    localparam int MAX_IN_DEF    = 32;
    localparam int BATCH_DEF     = 4;
    localparam int WORD_BITS_DEF = 16;

    localparam int FRAC = 12;

    localparam logic [2:0] OP_LOAD_IN  = 3'd0;
    localparam logic [2:0] OP_LOAD_REC = 3'd1;
    localparam logic [2:0] OP_LOAD_BIH = 3'd2;
    localparam logic [2:0] OP_LOAD_BHH = 3'd3;
    localparam logic [2:0] OP_FEED     = 3'd4;

    localparam logic [1:0] CFG_INPUT_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HIDDEN_WIDTH = 2'd1;
    localparam logic [1:0] CFG_LAYER_COUNT  = 2'd2;
    localparam logic [1:0] CFG_USE_TANH     = 2'd3;

    // tanh on [0,4] in steps of 1/8, Q.12
    localparam logic [12:0] TANH_TAB [33] = '{
        13'd0,    13'd509,  13'd1003, 13'd1468, 13'd1893, 13'd2272, 13'd2602,
        13'd2883, 13'd3119, 13'd3315, 13'd3475, 13'd3604, 13'd3707, 13'd3790,
        13'd3856, 13'd3908, 13'd3949, 13'd3981, 13'd4006, 13'd4026, 13'd4041,
        13'd4053, 13'd4063, 13'd4070, 13'd4076, 13'd4080, 13'd4084, 13'd4086,
        13'd4089, 13'd4090, 13'd4091, 13'd4092, 13'd4093
    };

    typedef struct packed {
        logic load_in;
        logic load_rec;
        logic load_bih;
        logic load_bhh;
    } cell_load_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic rec;
    } tok_t;

    typedef struct packed {
        logic wr;
        logic zero;
        logic emit;
        logic last;
    } act_tag_t;

    function automatic int clog2m(input int v);
        int r;
        r = $clog2(v);
        return (r < 1) ? 1 : r;
    endfunction

endpackage

@@ src/erf_cell.sv @@
// One hidden-unit MAC cell: own weight rows, systolic token hop, shiftable accumulator.
`timescale 1ns / 1ps
module erf_cell
    import erf_pkg::*;
#(
    parameter int LAYERS    = LAYERS_DEF,
    parameter int HIDDEN    = HIDDEN_DEF,
    parameter int MAX_IN    = MAX_IN_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int CELL_ID   = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cell_load_t                             ld,
    input  logic [clog2m(HIDDEN)-1:0]              ld_row,
    input  logic [clog2m(LAYERS)-1:0]              ld_layer,
    input  logic [clog2m((MAX_IN > HIDDEN) ? MAX_IN : HIDDEN)-1:0] ld_col,
    input  logic signed [WORD_BITS-1:0]            ld_data,
    input  logic [clog2m(LAYERS)-1:0]              cur_layer,
    input  tok_t                                   tok_in,
    input  logic [clog2m((MAX_IN > HIDDEN) ? MAX_IN : HIDDEN)-1:0] idx_in,
    input  logic signed [WORD_BITS-1:0]            data_in,
    output tok_t                                   tok_out,
    output logic [clog2m((MAX_IN > HIDDEN) ? MAX_IN : HIDDEN)-1:0] idx_out,
    output logic signed [WORD_BITS-1:0]            data_out,
    input  logic                                   shift,
    input  logic signed [2*WORD_BITS+7:0]          acc_in,
    output logic signed [2*WORD_BITS+7:0]          acc_out
);

    localparam int IN_STRIDE = (MAX_IN > HIDDEN) ? MAX_IN : HIDDEN;
    localparam int W         = WORD_BITS;
    localparam int ACC_W     = 2 * W + 8;
    localparam int HID_W     = clog2m(HIDDEN);
    localparam int WI_D      = LAYERS * IN_STRIDE;
    localparam int WR_D      = LAYERS * HIDDEN;
    localparam int WI_AW     = clog2m(WI_D);
    localparam int WR_AW     = clog2m(WR_D);

    logic signed [W-1:0]     win_mem  [WI_D];
    logic signed [W-1:0]     wrec_mem [WR_D];
    logic signed [W-1:0]     bih_mem  [LAYERS];
    logic signed [W-1:0]     bhh_mem  [LAYERS];

    logic                    sel;
    logic [WI_AW-1:0]        wi_waddr, wi_raddr;
    logic [WR_AW-1:0]        wr_waddr, wr_raddr;
    logic signed [W-1:0]     wi_q_reg, wr_q_reg;
    logic signed [W:0]       bsum_reg;
    tok_t                    tok_a_reg;
    logic [$bits(idx_in)-1:0] idx_a_reg;
    logic signed [W-1:0]     data_a_reg;
    logic signed [W-1:0]     w_sel;
    logic signed [2*W-1:0]   prod_next, prod_reg;
    logic                    vb_reg, fb_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    assign sel      = (ld_row == HID_W'(CELL_ID));
    assign wi_waddr = WI_AW'(int'(ld_layer) * IN_STRIDE + int'(ld_col));
    assign wr_waddr = WR_AW'(int'(ld_layer) * HIDDEN + int'(ld_col));
    assign wi_raddr = WI_AW'(int'(cur_layer) * IN_STRIDE + int'(idx_in));
    assign wr_raddr = WR_AW'(int'(cur_layer) * HIDDEN + int'(idx_in));

    always_ff @(posedge clk)
    begin
        if (sel && ld.load_in)
        begin
            win_mem[wi_waddr] <= ld_data;
        end
        if (sel && ld.load_rec)
        begin
            wrec_mem[wr_waddr] <= ld_data;
        end
        if (sel && ld.load_bih)
        begin
            bih_mem[ld_layer] <= ld_data;
        end
        if (sel && ld.load_bhh)
        begin
            bhh_mem[ld_layer] <= ld_data;
        end
        wi_q_reg   <= win_mem[wi_raddr];
        wr_q_reg   <= wrec_mem[wr_raddr];
        bsum_reg   <= (W+1)'(bih_mem[cur_layer]) + (W+1)'(bhh_mem[cur_layer]);
        idx_a_reg  <= idx_in;
        data_a_reg <= data_in;
        prod_reg   <= prod_next;
    end

    assign w_sel     = tok_a_reg.rec ? wr_q_reg : wi_q_reg;
    assign prod_next = (2*W)'(w_sel) * (2*W)'(data_a_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (shift)
        begin
            acc_next = acc_in;
        end
        else if (vb_reg)
        begin
            if (fb_reg)
            begin
                acc_next = (ACC_W'(bsum_reg) <<< FRAC) + ACC_W'(prod_reg);
            end
            else
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg <= '0;
            vb_reg    <= 1'b0;
            fb_reg    <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            tok_a_reg <= tok_in;
            vb_reg    <= tok_a_reg.valid;
            fb_reg    <= tok_a_reg.first;
            acc_reg   <= acc_next;
        end
    end

    assign tok_out  = tok_a_reg;
    assign idx_out  = idx_a_reg;
    assign data_out = data_a_reg;
    assign acc_out  = acc_reg;

endmodule

@@ src/erf_act.sv @@
// Round, activate (tanh table or ReLU) and saturate one accumulator; 3 stages.
`timescale 1ns / 1ps
module erf_act
    import erf_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int UNIT_W    = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic signed [2*WORD_BITS+7:0] acc,
    input  logic                          use_tanh,
    input  act_tag_t                      tag_in,
    input  logic [UNIT_W-1:0]             unit_in,
    output logic                          done,
    output act_tag_t                      tag_out,
    output logic [UNIT_W-1:0]             unit_out,
    output logic signed [WORD_BITS-1:0]   result
);

    localparam int W     = WORD_BITS;
    localparam int ACC_W = 2 * W + 8;
    localparam int QW    = ACC_W - FRAC;
    localparam int MAG_W = (QW + 1 > 15) ? QW + 1 : 15;
    localparam int AW    = ((QW > 14) ? QW : 14) + 1;
    localparam logic signed [AW-1:0] HI = AW'((longint'(1) <<< (W - 1)) - 1);
    localparam logic signed [AW-1:0] LO = -HI - AW'(1);

    logic signed [ACC_W-1:0] rnd;
    logic signed [QW-1:0]    q1_reg, q2_reg;
    logic                    v1_reg, v2_reg, v3_reg;
    act_tag_t                t1_reg, t2_reg, t3_reg;
    logic [UNIT_W-1:0]       u1_reg, u2_reg, u3_reg;
    logic                    th1_reg, th2_reg;
    logic [MAG_W-1:0]        mag;
    logic                    big;
    logic [4:0]              ti;
    logic                    neg_reg;
    logic [12:0]             y0_reg, d_reg;
    logic [8:0]              f_reg;
    logic [19:0]             interp;
    logic [12:0]             y;
    logic signed [AW-1:0]    act_v;
    logic signed [W-1:0]     sat_v, res_reg;

    assign rnd = acc + ACC_W'(2048);

    // stage 2 inputs
    assign mag = q1_reg[QW-1] ? MAG_W'(-(QW+1)'(q1_reg)) : MAG_W'((QW+1)'(q1_reg));
    assign big = (mag >= MAG_W'(16384));
    assign ti  = mag[13:9];

    // stage 3
    assign interp = 20'(d_reg) * 20'(f_reg) + 20'd256;
    assign y      = y0_reg + 13'(interp >> 9);

    always_comb
    begin
        if (th2_reg)
        begin
            act_v = neg_reg ? -AW'(y) : AW'(y);
        end
        else
        begin
            act_v = (q2_reg > 0) ? AW'(q2_reg) : '0;
        end
        if (act_v > HI)
        begin
            sat_v = W'(HI);
        end
        else if (act_v < LO)
        begin
            sat_v = W'(LO);
        end
        else
        begin
            sat_v = W'(act_v);
        end
    end

    always_ff @(posedge clk)
    begin
        q1_reg  <= rnd[ACC_W-1:FRAC];
        u1_reg  <= unit_in;
        t1_reg  <= tag_in;
        th1_reg <= use_tanh;
        q2_reg  <= q1_reg;
        u2_reg  <= u1_reg;
        t2_reg  <= t1_reg;
        th2_reg <= th1_reg;
        neg_reg <= q1_reg[QW-1];
        f_reg   <= big ? 9'd0 : mag[8:0];
        y0_reg  <= big ? TANH_TAB[32] : TANH_TAB[{1'b0, ti}];
        d_reg   <= big ? 13'd0 : TANH_TAB[{1'b0, ti} + 6'd1] - TANH_TAB[{1'b0, ti}];
        u3_reg  <= u2_reg;
        t3_reg  <= t2_reg;
        res_reg <= sat_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign done     = v3_reg;
    assign tag_out  = t3_reg;
    assign unit_out = u3_reg;
    assign result   = res_reg;

endmodule

@@ src/elman_rnn_forward_step.sv @@
// Top level: stacked Elman RNN forward step over a chain of MAC cells.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid/in_stall) takes load and feed requests. Loads write
//  weights and biases into the cells as they are taken. A feed writes one element
//  of a slot's input vector; the element marked last starts a time step.
//  While a step runs in_stall is high; loads and feeds are taken at one per
//  cycle otherwise, also while results still wait on the output side.
//  A step runs each layer as: stream of (nin + hw) operands into the cell
//  chain, chain drain, accumulator unload through the activation unit, and
//  write-back, nin being the layer's input count. The output channel
//  (out_valid/out_stall) gives the top layer's hw units in order, out_last on
//  the final one; a 4-entry queue holds them, and the unload pauses while the
//  queue has no room, so a stalled receiver only slows the step. Reset clears
//  hidden state (all slots read as zero), config to defaults; weights, biases
//  and inputs are undefined until loaded. cfg_we writes a register; write
//  only while no step runs.
`include "assert_macros.svh"
module elman_rnn_forward_step
    import erf_pkg::*;
#(
    parameter int LAYERS    = LAYERS_DEF,
    parameter int HIDDEN    = HIDDEN_DEF,
    parameter int MAX_IN    = MAX_IN_DEF,
    parameter int BATCH     = BATCH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [5:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         operation,
    input  logic [1:0]         layer,
    input  logic [4:0]         unit_row,
    input  logic [4:0]         column,
    input  logic signed [15:0] value,
    input  logic [1:0]         slot,
    input  logic               sequence_start,
    input  logic               last_element,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         out_slot,
    output logic [4:0]         out_unit,
    output logic signed [15:0] out_value,
    output logic               out_last
);

    localparam int IN_STRIDE = (MAX_IN > HIDDEN) ? MAX_IN : HIDDEN;
    localparam int W         = WORD_BITS;
    localparam int ACC_W     = 2 * W + 8;
    localparam int LAY_W     = clog2m(LAYERS);
    localparam int SLOT_W    = clog2m(BATCH);
    localparam int HID_W     = clog2m(HIDDEN);
    localparam int IDX_W     = clog2m(IN_STRIDE);
    localparam int NW        = clog2m(IN_STRIDE + 1);
    localparam int LC_W      = clog2m(LAYERS + 1);
    localparam int CNT_W     = clog2m(MAX_IN + HIDDEN + 1);
    localparam int ROWS      = LAYERS * BATCH;
    localparam int ROW_W     = clog2m(ROWS);
    localparam int HS_D      = ROWS * HIDDEN;
    localparam int HS_AW     = clog2m(HS_D);
    localparam int IB_D      = BATCH * MAX_IN;
    localparam int IB_AW     = clog2m(IB_D);
    localparam int DR_W      = clog2m(HIDDEN + 5);
    localparam int U_W       = clog2m(HIDDEN + 1);
    localparam int FDEPTH    = 4;
    localparam int FP_W      = 2;
    localparam int FC_W      = 3;
    localparam int EW        = (W > 16) ? W : 16;
    localparam logic signed [EW-1:0] W_HI = EW'((longint'(1) <<< (W - 1)) - 1);
    localparam logic signed [EW-1:0] W_LO = -W_HI - EW'(1);
    localparam logic signed [EW-1:0] S_HI = EW'(32767);
    localparam logic signed [EW-1:0] S_LO = -S_HI - EW'(1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_STREAM = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_UNLOAD = 5'b01000,
        S_FLUSH  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [5:0] iw_cfg_reg, hw_cfg_reg;
    logic [2:0] lc_cfg_reg;
    logic       tanh_cfg_reg;
    logic [NW-1:0]   iw, hw, nin;
    logic [LC_W-1:0] lc;

    // request decode
    logic                in_acc;
    logic signed [EW-1:0] v_ext;
    logic signed [W-1:0] val_w;
    logic                ld_ok, feed_ok, step_go;
    cell_load_t          ld;
    logic [SLOT_W-1:0]   slot_idx;

    // sequencer
    logic [LAY_W-1:0]  layer_reg, layer_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [DR_W-1:0]   dr_reg, dr_next;
    logic [U_W-1:0]    u_reg, u_next;
    logic              zfill_reg, zfill_next;
    logic [ROWS-1:0]   row_valid_reg;
    logic [ROW_W-1:0]  row_cur, row_prev, row_rd;
    logic              top, active, need_credit, issue, k_rec;
    logic [IDX_W-1:0]  k_idx;

    // operand issue
    tok_t              iss_tok_reg;
    logic [IDX_W-1:0]  iss_idx_reg;
    logic              iss_ib_reg, iss_zero_reg;
    logic signed [W-1:0] ib_q_reg, hs_q_reg, op_data;
    logic signed [W-1:0] ib_mem [IB_D];
    logic signed [W-1:0] hs_mem [HS_D];
    logic [IB_AW-1:0]  ib_waddr, ib_raddr;
    logic [HS_AW-1:0]  hs_waddr, hs_raddr;

    // cell chain
    tok_t                    ch_tok  [HIDDEN+1];
    logic [IDX_W-1:0]        ch_idx  [HIDDEN+1];
    logic signed [W-1:0]     ch_data [HIDDEN+1];
    logic signed [ACC_W-1:0] ch_acc  [HIDDEN+1];

    // activation and output queue
    act_tag_t            a_tag_in, a_tag_out;
    logic                a_done;
    logic [HID_W-1:0]    a_unit;
    logic signed [W-1:0] a_res;
    logic signed [EW-1:0] r_ext;
    logic signed [15:0]  r16;
    logic                push, pop;
    logic [FC_W-1:0]     occ_reg, fcnt_reg;
    logic [FP_W-1:0]     wp_reg, rp_reg;
    logic [1:0]          fq_slot [FDEPTH];
    logic [4:0]          fq_unit [FDEPTH];
    logic signed [15:0]  fq_val  [FDEPTH];
    logic                fq_last [FDEPTH];

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_cfg_reg   <= 6'd32;
            hw_cfg_reg   <= 6'd32;
            lc_cfg_reg   <= 3'd1;
            tanh_cfg_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INPUT_WIDTH:  iw_cfg_reg   <= cfg_data;
                CFG_HIDDEN_WIDTH: hw_cfg_reg   <= cfg_data;
                CFG_LAYER_COUNT:  lc_cfg_reg   <= cfg_data[2:0];
                CFG_USE_TANH:     tanh_cfg_reg <= cfg_data[0];
                default:          tanh_cfg_reg <= tanh_cfg_reg;
            endcase
        end
    end

    assign iw = (iw_cfg_reg == 6'd0) ? NW'(1) :
                ((int'(iw_cfg_reg) > MAX_IN) ? NW'(MAX_IN) : NW'(iw_cfg_reg));
    assign hw = (hw_cfg_reg == 6'd0) ? NW'(1) :
                ((int'(hw_cfg_reg) > HIDDEN) ? NW'(HIDDEN) : NW'(hw_cfg_reg));
    assign lc = (lc_cfg_reg == 3'd0) ? LC_W'(1) :
                ((int'(lc_cfg_reg) > LAYERS) ? LC_W'(LAYERS) : LC_W'(lc_cfg_reg));

    // ---------------- request decode ----------------
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign v_ext    = EW'(value);
    assign val_w    = (v_ext > W_HI) ? W'(W_HI) : ((v_ext < W_LO) ? W'(W_LO) : W'(v_ext));
    assign slot_idx = SLOT_W'(slot);

    assign ld_ok = in_acc && (operation <= OP_LOAD_BHH) && (int'(layer) < LAYERS)
                   && (int'(unit_row) < HIDDEN);
    assign ld.load_in  = ld_ok && (operation == OP_LOAD_IN) && (int'(column) < IN_STRIDE);
    assign ld.load_rec = ld_ok && (operation == OP_LOAD_REC) && (int'(column) < HIDDEN);
    assign ld.load_bih = ld_ok && (operation == OP_LOAD_BIH);
    assign ld.load_bhh = ld_ok && (operation == OP_LOAD_BHH);

    assign feed_ok = in_acc && (operation == OP_FEED) && (int'(slot) < BATCH);
    assign step_go = feed_ok && last_element;

    assign ib_waddr = IB_AW'(int'(slot_idx) * MAX_IN + int'(column));

    // ---------------- sequencer ----------------
    assign row_cur  = ROW_W'(int'(layer_reg) * BATCH + int'(slot_reg));
    assign row_prev = ROW_W'((int'(layer_reg) - 1) * BATCH + int'(slot_reg));
    assign nin      = (layer_reg == '0) ? iw : hw;
    assign k_rec    = (int'(k_reg) >= int'(nin));
    assign k_idx    = k_rec ? IDX_W'(int'(k_reg) - int'(nin)) : IDX_W'(k_reg);
    assign row_rd   = k_rec ? row_cur : row_prev;
    assign ib_raddr = IB_AW'(int'(slot_reg) * MAX_IN + int'(k_idx));
    assign hs_raddr = HS_AW'(int'(row_rd) * HIDDEN + int'(k_idx));

    assign top         = (int'(layer_reg) == int'(lc) - 1);
    assign active      = (int'(u_reg) < int'(hw));
    assign need_credit = top && active;
    assign issue       = (state_reg == S_UNLOAD)
                         && (!need_credit || (int'(occ_reg) < FDEPTH));

    always_comb
    begin
        state_next = state_reg;
        layer_next = layer_reg;
        slot_next  = slot_reg;
        k_next     = k_reg;
        dr_next    = dr_reg;
        u_next     = u_reg;
        zfill_next = zfill_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (step_go)
                begin
                    state_next = S_STREAM;
                    layer_next = '0;
                    slot_next  = slot_idx;
                    k_next     = '0;
                end
            end
            S_STREAM:
            begin
                k_next = k_reg + CNT_W'(1);
                if (int'(k_reg) == int'(nin) + int'(hw) - 1)
                begin
                    state_next = S_DRAIN;
                    dr_next    = '0;
                end
            end
            S_DRAIN:
            begin
                dr_next = dr_reg + DR_W'(1);
                if (int'(dr_reg) == HIDDEN + 3)
                begin
                    state_next = S_UNLOAD;
                    u_next     = '0;
                    zfill_next = !row_valid_reg[row_cur];
                end
            end
            S_UNLOAD:
            begin
                if (issue)
                begin
                    u_next = u_reg + U_W'(1);
                    if (int'(u_reg) == HIDDEN - 1)
                    begin
                        state_next = S_FLUSH;
                        dr_next    = '0;
                    end
                end
            end
            S_FLUSH:
            begin
                dr_next = dr_reg + DR_W'(1);
                if (dr_reg == DR_W'(3))
                begin
                    if (top)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_STREAM;
                        layer_next = layer_reg + LAY_W'(1);
                        k_next     = '0;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            layer_reg     <= '0;
            slot_reg      <= '0;
            k_reg         <= '0;
            dr_reg        <= '0;
            u_reg         <= '0;
            zfill_reg     <= 1'b0;
            row_valid_reg <= '0;
            iss_tok_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            slot_reg  <= slot_next;
            k_reg     <= k_next;
            dr_reg    <= dr_next;
            u_reg     <= u_next;
            zfill_reg <= zfill_next;
            // a cleared row reads as zero until the layer writes it back
            if (feed_ok && sequence_start)
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    if ((r % BATCH) == int'(slot_idx))
                    begin
                        row_valid_reg[r] <= 1'b0;
                    end
                end
            end
            if (state_reg == S_FLUSH && dr_reg == DR_W'(3))
            begin
                row_valid_reg[row_cur] <= 1'b1;
            end
            iss_tok_reg.valid <= (state_reg == S_STREAM);
            iss_tok_reg.first <= (k_reg == '0);
            iss_tok_reg.rec   <= k_rec;
        end
    end

    // ---------------- operand memories ----------------
    always_ff @(posedge clk)
    begin
        if (feed_ok && (int'(column) < MAX_IN))
        begin
            ib_mem[ib_waddr] <= val_w;
        end
        if (a_done && a_tag_out.wr)
        begin
            hs_mem[hs_waddr] <= a_tag_out.zero ? '0 : a_res;
        end
        ib_q_reg     <= ib_mem[ib_raddr];
        hs_q_reg     <= hs_mem[hs_raddr];
        iss_idx_reg  <= k_idx;
        iss_ib_reg   <= (layer_reg == '0) && !k_rec;
        iss_zero_reg <= k_rec && !row_valid_reg[row_cur];
    end

    assign op_data = iss_ib_reg ? ib_q_reg : (iss_zero_reg ? '0 : hs_q_reg);

    // ---------------- cell chain ----------------
    assign ch_tok[0]       = iss_tok_reg;
    assign ch_idx[0]       = iss_idx_reg;
    assign ch_data[0]      = op_data;
    assign ch_acc[HIDDEN]  = '0;

    for (genvar c = 0; c < HIDDEN; c++)
    begin : g_cell
        erf_cell #(
            .LAYERS    (LAYERS),
            .HIDDEN    (HIDDEN),
            .MAX_IN    (MAX_IN),
            .WORD_BITS (WORD_BITS),
            .CELL_ID   (c)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ld        (ld),
            .ld_row    (HID_W'(unit_row)),
            .ld_layer  (LAY_W'(layer)),
            .ld_col    (IDX_W'(column)),
            .ld_data   (val_w),
            .cur_layer (layer_reg),
            .tok_in    (ch_tok[c]),
            .idx_in    (ch_idx[c]),
            .data_in   (ch_data[c]),
            .tok_out   (ch_tok[c+1]),
            .idx_out   (ch_idx[c+1]),
            .data_out  (ch_data[c+1]),
            .shift     (issue),
            .acc_in    (ch_acc[c+1]),
            .acc_out   (ch_acc[c])
        );
    end

    // ---------------- activation ----------------
    assign a_tag_in.wr   = active || zfill_reg;
    assign a_tag_in.zero = !active;
    assign a_tag_in.emit = top && active;
    assign a_tag_in.last = (int'(u_reg) == int'(hw) - 1);

    erf_act #(
        .WORD_BITS (WORD_BITS),
        .UNIT_W    (HID_W)
    ) u_act (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (issue),
        .acc      (ch_acc[0]),
        .use_tanh (tanh_cfg_reg),
        .tag_in   (a_tag_in),
        .unit_in  (HID_W'(u_reg)),
        .done     (a_done),
        .tag_out  (a_tag_out),
        .unit_out (a_unit),
        .result   (a_res)
    );

    assign hs_waddr = HS_AW'(int'(row_cur) * HIDDEN + int'(a_unit));

    // ---------------- output queue ----------------
    assign r_ext = EW'(a_res);
    assign r16   = (r_ext > S_HI) ? 16'sh7fff : ((r_ext < S_LO) ? 16'sh8000 : 16'(r_ext));
    assign push  = a_done && a_tag_out.emit;
    assign pop   = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fq_slot[wp_reg] <= 2'(slot_reg);
            fq_unit[wp_reg] <= 5'(a_unit);
            fq_val[wp_reg]  <= r16;
            fq_last[wp_reg] <= a_tag_out.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fcnt_reg <= '0;
            occ_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + FP_W'(1);
            end
            if (pop)
            begin
                rp_reg <= rp_reg + FP_W'(1);
            end
            fcnt_reg <= fcnt_reg + FC_W'(push) - FC_W'(pop);
            // credit counts top-layer output results issued to the activation but not yet taken
            occ_reg  <= occ_reg + FC_W'(issue && need_credit) - FC_W'(pop);
        end
    end

    assign out_valid = (fcnt_reg != '0);
    assign out_slot  = fq_slot[rp_reg];
    assign out_unit  = fq_unit[rp_reg];
    assign out_value = fq_val[rp_reg];
    assign out_last  = fq_last[rp_reg];

    // ---------------- assertions ----------------
    `ASSERT_IMPL(a_credit_bound, clk, rst_n, 1'b1, occ_reg <= FC_W'(FDEPTH))
    `ASSERT_IMPL(a_no_overflow, clk, rst_n, push, (fcnt_reg < FC_W'(FDEPTH)) || pop)
    `ASSERT_IMPL(a_queue_in_credit, clk, rst_n, 1'b1, fcnt_reg <= occ_reg)
    `ASSERT_NEXT(a_step_starts, clk, rst_n, step_go, state_reg == S_STREAM)

endmodule
